// ===== hw/rtl/idn_pkg.sv =====
`timescale 1ns / 1ps

package idn_pkg;

    localparam int ENTRIES   = 16;
    localparam int MAX_BYTES = 32;

    // I/O always carries four 64-bit words; storage keeps only what MAX_BYTES needs
    localparam int IO_WORDS = 4;
    localparam int WORDS    = (MAX_BYTES + 7) / 8;
    localparam int WSEL_W   = 2;
    localparam int LEN_W    = 6;
    localparam int KEY_W    = 16;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int ADDR_W = (ENTRIES * WORDS > 1) ? $clog2(ENTRIES * WORDS) : 1;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CYCLIC = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_LEN   = 2'd3;

    localparam logic [KEY_W-1:0] CYC_WRITE_KEY   = 16'd36;
    localparam logic [KEY_W-1:0] CYC_READ_KEY    = 16'd51;
    localparam logic [LEN_W-1:0] CYC_WRITE_BYTES = 6'd4;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] byte_count;
        logic [63:0]      data_word0;
        logic [63:0]      data_word1;
        logic [63:0]      data_word2;
        logic [63:0]      data_word3;
    } request_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [LEN_W-1:0] read_length;
        logic [63:0]      read_word0;
        logic [63:0]      read_word1;
        logic [63:0]      read_word2;
        logic [63:0]      read_word3;
    } result_t;

    typedef struct packed {
        logic       load;
        logic       scan_init;
        logic       scan;
        logic       alloc;
        logic       wr_word;
        logic       rd_issue;
        logic       rd_finish;
        logic       phase_read;
        logic       set_status;
        logic [1:0] status_code;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       bad_len;
        logic       scan_done;
        logic       hit;
        logic       full;
        logic       w_last;
    } dp_status_t;

    // keeps the bytes of word w that lie below a length of n bytes
    function automatic logic [63:0] byte_mask(input logic [LEN_W-1:0] n,
                                              input logic [WSEL_W-1:0] w);
        logic [63:0] m;
        int          lo;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            lo = int'(w) * 8 + b;
            m[b*8 +: 8] = (int'(n) > lo) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/idn_ctrl.sv =====
`timescale 1ns / 1ps

module idn_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          opcode,
    input  idn_pkg::dp_status_t st,
    output idn_pkg::dp_cmd_t    cmd,
    output logic                busy,
    output logic                done
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_WKEY   = 3'd2;
    localparam logic [2:0] S_WDATA  = 3'd3;
    localparam logic [2:0] S_RDATA  = 3'd4;
    localparam logic [2:0] S_RDRAIN = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       phase_reg, phase_next;   // cyclic: 0 write half, 1 read half
    logic       writing;

    assign writing = (st.op == idn_pkg::OP_WRITE) ||
                     ((st.op == idn_pkg::OP_CYCLIC) && !phase_reg);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load      = 1'b1;
                    cmd.scan_init = 1'b1;
                    phase_next    = 1'b0;
                    state_next    = (opcode == idn_pkg::OP_NONE) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (writing && st.bad_len)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = idn_pkg::ST_BAD_LEN;
                    state_next      = S_DONE;
                end
                else if (st.scan_done)
                begin
                    if (writing)
                    begin
                        if (!st.hit && st.full)
                        begin
                            if (st.op == idn_pkg::OP_WRITE)
                            begin
                                cmd.set_status  = 1'b1;
                                cmd.status_code = idn_pkg::ST_FULL;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                cmd.phase_read = 1'b1;
                                phase_next     = 1'b1;
                                state_next     = S_SCAN;
                            end
                        end
                        else
                        begin
                            state_next = S_WKEY;
                        end
                    end
                    else if (st.hit)
                    begin
                        state_next = S_RDATA;
                    end
                    else
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = idn_pkg::ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                end
            end
            S_WKEY:
            begin
                cmd.alloc  = 1'b1;
                state_next = S_WDATA;
            end
            S_WDATA:
            begin
                cmd.wr_word = 1'b1;
                if (st.w_last)
                begin
                    if (st.op == idn_pkg::OP_CYCLIC)
                    begin
                        cmd.phase_read = 1'b1;
                        phase_next     = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RDATA:
            begin
                cmd.rd_issue = 1'b1;
                if (st.w_last)
                begin
                    state_next = S_RDRAIN;
                end
            end
            S_RDRAIN:
            begin
                cmd.rd_finish = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

// ===== hw/rtl/idn_dpath.sv =====
`timescale 1ns / 1ps

module idn_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  idn_pkg::request_t   request,
    input  idn_pkg::dp_cmd_t    cmd,
    output idn_pkg::dp_status_t st,
    output idn_pkg::result_t    result
);

    localparam int IDX_W  = idn_pkg::IDX_W;
    localparam int CNT_W  = idn_pkg::CNT_W;
    localparam int ADDR_W = idn_pkg::ADDR_W;
    localparam int WSEL_W = idn_pkg::WSEL_W;
    localparam int LEN_W  = idn_pkg::LEN_W;
    localparam int KEY_W  = idn_pkg::KEY_W;

    // storage
    logic [KEY_W-1:0] key_mem  [idn_pkg::ENTRIES];
    logic [LEN_W-1:0] len_mem  [idn_pkg::ENTRIES];
    logic [63:0]      byte_mem [idn_pkg::ENTRIES * idn_pkg::WORDS];

    // control
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  scan_reg;
    logic              pend_key_reg;
    logic              found_reg;
    logic              pend_rd_reg;
    logic [WSEL_W-1:0] wcnt_reg;

    // payload
    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [LEN_W-1:0]  n_reg;
    logic [63:0]       wdata_reg [idn_pkg::IO_WORDS];
    logic [KEY_W-1:0]  key_rd_reg;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [LEN_W-1:0]  len_rd_reg;
    logic [63:0]       byte_rd_reg;
    logic [WSEL_W-1:0] cap_w_reg;
    logic [1:0]        res_status_reg;
    logic [LEN_W-1:0]  res_len_reg;
    logic [63:0]       res_word_reg [idn_pkg::IO_WORDS];

    logic             hit_now;
    logic             exhausted;
    logic             issue_key;
    logic [IDX_W-1:0] count_idx;
    logic [IDX_W-1:0] tgt_idx;
    logic [ADDR_W-1:0] byte_addr;

    assign hit_now   = pend_key_reg && (key_rd_reg == key_reg);
    assign exhausted = !pend_key_reg && (scan_reg >= count_reg);
    assign issue_key = cmd.scan && !hit_now && (scan_reg < count_reg);
    assign count_idx = count_reg[IDX_W-1:0];
    assign tgt_idx   = found_reg ? hit_idx_reg : count_idx;
    assign byte_addr = ADDR_W'(hit_idx_reg) * ADDR_W'(idn_pkg::WORDS) + ADDR_W'(wcnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            scan_reg     <= '0;
            pend_key_reg <= 1'b0;
            found_reg    <= 1'b0;
            pend_rd_reg  <= 1'b0;
            wcnt_reg     <= '0;
        end
        else
        begin
            pend_rd_reg <= cmd.rd_issue;
            if (cmd.scan_init || cmd.phase_read)
            begin
                scan_reg     <= '0;
                pend_key_reg <= 1'b0;
                found_reg    <= 1'b0;
                wcnt_reg     <= '0;
            end
            else
            begin
                if (cmd.scan)
                begin
                    pend_key_reg <= issue_key;
                    if (issue_key)
                    begin
                        scan_reg <= scan_reg + CNT_W'(1);
                    end
                    if (hit_now)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                if (cmd.alloc)
                begin
                    wcnt_reg <= '0;
                    if (!found_reg)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                if (cmd.wr_word || cmd.rd_issue)
                begin
                    wcnt_reg <= wcnt_reg + WSEL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= request.opcode;
            if (request.opcode == idn_pkg::OP_CYCLIC)
            begin
                key_reg      <= idn_pkg::CYC_WRITE_KEY;
                n_reg        <= idn_pkg::CYC_WRITE_BYTES;
                wdata_reg[0] <= {32'h0, request.data_word0[31:0]};
                wdata_reg[1] <= '0;
                wdata_reg[2] <= '0;
                wdata_reg[3] <= '0;
            end
            else
            begin
                key_reg      <= request.key;
                n_reg        <= request.byte_count;
                wdata_reg[0] <= request.data_word0;
                wdata_reg[1] <= request.data_word1;
                wdata_reg[2] <= request.data_word2;
                wdata_reg[3] <= request.data_word3;
            end
            res_status_reg <= idn_pkg::ST_OK;
            res_len_reg    <= '0;
            for (int w = 0; w < idn_pkg::IO_WORDS; w++)
            begin
                res_word_reg[w] <= '0;
            end
        end
        if (cmd.phase_read)
        begin
            key_reg <= idn_pkg::CYC_READ_KEY;
        end
        if (issue_key)
        begin
            key_rd_reg   <= key_mem[scan_reg[IDX_W-1:0]];
            pend_idx_reg <= scan_reg[IDX_W-1:0];
        end
        if (cmd.scan && hit_now)
        begin
            hit_idx_reg <= pend_idx_reg;
        end
        if (cmd.alloc)
        begin
            hit_idx_reg      <= tgt_idx;
            len_mem[tgt_idx] <= n_reg;
            if (!found_reg)
            begin
                key_mem[count_idx] <= key_reg;
            end
        end
        if (cmd.wr_word)
        begin
            byte_mem[byte_addr] <= wdata_reg[wcnt_reg] & idn_pkg::byte_mask(n_reg, wcnt_reg);
        end
        if (cmd.rd_issue)
        begin
            byte_rd_reg <= byte_mem[byte_addr];
            cap_w_reg   <= wcnt_reg;
        end
        len_rd_reg <= len_mem[hit_idx_reg];
        if (pend_rd_reg)
        begin
            res_word_reg[cap_w_reg] <= byte_rd_reg & idn_pkg::byte_mask(len_rd_reg, cap_w_reg);
        end
        if (cmd.rd_finish)
        begin
            res_len_reg <= len_rd_reg;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status_code;
        end
    end

    assign st.op        = op_reg;
    assign st.bad_len   = (n_reg == '0) || (n_reg > LEN_W'(idn_pkg::MAX_BYTES));
    assign st.scan_done = hit_now || exhausted;
    assign st.hit       = hit_now;
    assign st.full      = (count_reg == CNT_W'(idn_pkg::ENTRIES));
    assign st.w_last    = (wcnt_reg == WSEL_W'(idn_pkg::WORDS - 1));

    assign result.status      = res_status_reg;
    assign result.read_length = res_len_reg;
    assign result.read_word0  = res_word_reg[0];
    assign result.read_word1  = res_word_reg[1];
    assign result.read_word2  = res_word_reg[2];
    assign result.read_word3  = res_word_reg[3];

endmodule

// ===== hw/rtl/idn_parameter_table.sv =====
`timescale 1ns / 1ps

// Channel   Handshake            Payload               Transfer when
// -------   ------------------   -------------------   ---------------------------
// request   start / busy         idn_pkg::request_t    rising edge, start && !busy
// result    done (1-cycle pulse) idn_pkg::result_t     rising edge ending the pulse
//
// One request at a time. Busy covers the key search and then the word-by-word write or
// read of the stored words; a read miss or full table ends at the search, a bad write
// length ends it at once, an undefined opcode skips it, and the strobe closes each request.
// Cyclic runs its write half without the strobe cycle, then the read half.
// Reset clears only the entry count, the datapath control registers and the controller;
// entries are read below the count. The receiver cannot stall: the result pulse lasts one cycle, then busy drops.

module idn_parameter_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  idn_pkg::request_t request,
    output logic              done,
    output idn_pkg::result_t  result
);

    idn_pkg::dp_cmd_t    dp_cmd;
    idn_pkg::dp_status_t dp_status;

    // sequencer: search, allocate, word-by-word write or read
    idn_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (request.opcode),
        .st     (dp_status),
        .cmd    (dp_cmd),
        .busy   (busy),
        .done   (done)
    );

    // key, length and byte stores plus the result registers
    idn_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (dp_cmd),
        .st      (dp_status),
        .result  (result)
    );

    // accepted request keeps the block busy on the next cycle
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after request transfer");

    // result pulse is a single cycle and frees the block
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe not followed by idle");

    // only a successful read returns a length
    a_len_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != idn_pkg::ST_OK)) |->
            ((result.read_length == '0) && (result.read_word0 == '0)))
        else $error("failed access returned data");

    // no new command is issued while a result is shown
    a_no_cmd_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!dp_cmd.load && !dp_cmd.alloc && !dp_cmd.wr_word))
        else $error("datapath command during result cycle");

endmodule
